// File: rtl/biq_pkg.sv
package biq_pkg;

    localparam int SAMPLE_W   = 32;
    localparam int COEFF_W    = 16;
    localparam int PROD_W     = SAMPLE_W + COEFF_W;
    localparam int ACC_W      = 50;
    localparam int FRAC_BITS  = 14;
    localparam int SCALED_W   = ACC_W - FRAC_BITS;
    localparam int NUM_COEFFS = 5;
    localparam int CFG_IDX_W  = 3;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [COEFF_W-1:0]  coeff_t;
    typedef logic signed [PROD_W-1:0]   prod_t;
    typedef logic signed [ACC_W-1:0]    acc_t;
    typedef coeff_t coeff_bank_t [NUM_COEFFS];

    // Coefficient register indexes
    localparam logic [CFG_IDX_W-1:0] REG_B0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_B1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_B2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_A1 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_A2 = 3'd4;

    localparam coeff_t  B0_RESET   = 16'sd16384;
    localparam acc_t    ROUND_HALF = 50'sd8192;
    localparam sample_t SAT_MAX    = 32'sh7FFF_FFFF;
    localparam sample_t SAT_MIN    = 32'sh8000_0000;

endpackage

// File: rtl/biq_mul.sv
module biq_mul
(
    input  logic             clk,
    input  biq_pkg::sample_t op_a,
    input  biq_pkg::coeff_t  op_b,
    output biq_pkg::prod_t   prod_reg
);

    // Signed 32x16 product, registered before use
    always_ff @(posedge clk)
    begin
        prod_reg <= biq_pkg::prod_t'(op_a) * biq_pkg::prod_t'(op_b);
    end

endmodule

// File: rtl/biq_cfg.sv
module biq_cfg
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              wr_en,
    input  logic [biq_pkg::CFG_IDX_W-1:0]     wr_index,
    input  biq_pkg::coeff_t                   wr_data,
    output biq_pkg::coeff_bank_t              coeff_reg
);

    // Drop writes to unknown indexes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coeff_reg[biq_pkg::REG_B0] <= biq_pkg::B0_RESET;
            coeff_reg[biq_pkg::REG_B1] <= '0;
            coeff_reg[biq_pkg::REG_B2] <= '0;
            coeff_reg[biq_pkg::REG_A1] <= '0;
            coeff_reg[biq_pkg::REG_A2] <= '0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                biq_pkg::REG_B0: coeff_reg[biq_pkg::REG_B0] <= wr_data;
                biq_pkg::REG_B1: coeff_reg[biq_pkg::REG_B1] <= wr_data;
                biq_pkg::REG_B2: coeff_reg[biq_pkg::REG_B2] <= wr_data;
                biq_pkg::REG_A1: coeff_reg[biq_pkg::REG_A1] <= wr_data;
                biq_pkg::REG_A2: coeff_reg[biq_pkg::REG_A2] <= wr_data;
                default: ;
            endcase
        end
    end

endmodule

// File: rtl/biquad_iir_q14_saturating.sv
// Biquad IIR filter, transposed direct form II, Q2.14 coefficients, saturating output.
// Output: sample_out is registered in step M1 from x*b0 plus acc_first, or later from y_reg if out is stalled.
// A new word is taken only when idle or in step M5, as the five products share one 32x16 multiplier.
// Reset: asynchronous, active low; clears both accumulators and the sequencer, loads
// coeff_b0 = 1.0 and the other coefficients with zero. Coefficient writes take no wait.
module biquad_iir_q14_saturating
(
    input  logic                              clk,
    input  logic                              rst_n,
    // input channel
    input  logic                              in_valid,
    output logic                              in_stall,
    input  biq_pkg::sample_t                  sample_in,
    input  logic                              clear_state,
    // output channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output biq_pkg::sample_t                  sample_out,
    // coefficient write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [biq_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  biq_pkg::coeff_t                   cfg_data
);

    // Sequencer steps. Each step issues one product; the product comes back in the next step.
    //   M0: issue x*b0
    //   M1: form y from x*b0 + acc_first; acc_first <= acc_second; issue x*b1
    //   M2: acc_first += x*b1; issue x*b2
    //   M3: acc_second <= x*b2; issue y*a1
    //   M4: acc_first += y*a1; issue y*a2
    //   M5: acc_second += y*a2; the next word may be accepted here
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_M0   = 3'd1;
    localparam logic [2:0] ST_M1   = 3'd2;
    localparam logic [2:0] ST_M2   = 3'd3;
    localparam logic [2:0] ST_M3   = 3'd4;
    localparam logic [2:0] ST_M4   = 3'd5;
    localparam logic [2:0] ST_M5   = 3'd6;

    logic [2:0]                state_reg, state_next;
    biq_pkg::sample_t          x_reg;
    logic                      clr_reg;
    biq_pkg::sample_t          y_reg;
    logic                      y_pend_reg, y_pend_next;
    logic                      out_valid_reg, out_valid_next;
    biq_pkg::sample_t          sample_out_reg, sample_out_next;
    biq_pkg::acc_t             acc_first_reg, acc_first_next;
    biq_pkg::acc_t             acc_second_reg, acc_second_next;

    biq_pkg::coeff_bank_t      coeff;
    biq_pkg::sample_t          mul_a;
    biq_pkg::coeff_t           mul_b;
    biq_pkg::prod_t            prod_reg;
    biq_pkg::acc_t             prod_ext;
    biq_pkg::acc_t             sum;
    logic signed [biq_pkg::SCALED_W-1:0] scaled;
    biq_pkg::sample_t          y_sat;
    logic                      in_accept;
    logic                      out_free;

    // Coefficient registers; writes are always taken
    assign cfg_ready = 1'b1;

    biq_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (cfg_valid),
        .wr_index  (cfg_index),
        .wr_data   (cfg_data),
        .coeff_reg (coeff)
    );

    // Shared multiplier: pick operands for the product issued in this step
    always_comb
    begin
        mul_a = x_reg;
        mul_b = coeff[biq_pkg::REG_B0];
        case (state_reg)
            ST_M1:   mul_b = coeff[biq_pkg::REG_B1];
            ST_M2:   mul_b = coeff[biq_pkg::REG_B2];
            ST_M3:
            begin
                mul_a = y_reg;
                mul_b = coeff[biq_pkg::REG_A1];
            end
            ST_M4:
            begin
                mul_a = y_reg;
                mul_b = coeff[biq_pkg::REG_A2];
            end
            default: ;
        endcase
    end

    biq_mul u_mul
    (
        .clk      (clk),
        .op_a     (mul_a),
        .op_b     (mul_b),
        .prod_reg (prod_reg)
    );

    assign prod_ext = biq_pkg::acc_t'(prod_reg);

    // Round half up, floor shift, then clamp to the signed 32-bit range
    always_comb
    begin
        sum    = prod_ext + (clr_reg ? '0 : acc_first_reg) + biq_pkg::ROUND_HALF;
        scaled = biq_pkg::SCALED_W'(sum >>> biq_pkg::FRAC_BITS);
        if (scaled > biq_pkg::SCALED_W'(biq_pkg::SAT_MAX))
            y_sat = biq_pkg::SAT_MAX;
        else if (scaled < biq_pkg::SCALED_W'(biq_pkg::SAT_MIN))
            y_sat = biq_pkg::SAT_MIN;
        else
            y_sat = biq_pkg::SAMPLE_W'(scaled);
    end

    // Take a new word when the sequencer is idle or finishing, and no result is held back
    assign in_stall  = !(((state_reg == ST_IDLE) || (state_reg == ST_M5)) && !y_pend_reg);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next      = state_reg;
        acc_first_next  = acc_first_reg;
        acc_second_next = acc_second_reg;
        case (state_reg)
            ST_IDLE: if (in_accept) state_next = ST_M0;
            ST_M0:   state_next = ST_M1;
            ST_M1:
            begin
                acc_first_next = clr_reg ? '0 : acc_second_reg;
                state_next     = ST_M2;
            end
            ST_M2:
            begin
                acc_first_next = acc_first_reg + prod_ext;
                state_next     = ST_M3;
            end
            ST_M3:
            begin
                acc_second_next = prod_ext;
                state_next      = ST_M4;
            end
            ST_M4:
            begin
                acc_first_next = acc_first_reg + prod_ext;
                state_next     = ST_M5;
            end
            ST_M5:
            begin
                acc_second_next = acc_second_reg + prod_ext;
                state_next      = in_accept ? ST_M0 : ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Output register with one spare word: hold y in y_reg while the output is stalled
    always_comb
    begin
        y_pend_next     = y_pend_reg;
        out_valid_next  = out_valid_reg;
        sample_out_next = sample_out_reg;
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        if (state_reg == ST_M1)
        begin
            if (out_free)
            begin
                out_valid_next  = 1'b1;
                sample_out_next = y_sat;
            end
            else
            begin
                y_pend_next = 1'b1;
            end
        end
        else if (y_pend_reg && out_free)
        begin
            out_valid_next  = 1'b1;
            sample_out_next = y_reg;
            y_pend_next     = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            y_pend_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
            acc_first_reg  <= '0;
            acc_second_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            y_pend_reg     <= y_pend_next;
            out_valid_reg  <= out_valid_next;
            acc_first_reg  <= acc_first_next;
            acc_second_reg <= acc_second_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            x_reg   <= sample_in;
            clr_reg <= clear_state;
        end
        if (state_reg == ST_M1)
            y_reg <= y_sat;
        sample_out_reg <= sample_out_next;
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;

`ifndef NO_ASSERTIONS
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg == ST_M0))
        else $error("accepted word did not start the sequence");

    a_m0_to_m1: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_M0) |=> (state_reg == ST_M1))
        else $error("sequencer skipped the output step");

    a_pend_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        y_pend_reg |-> out_valid_reg)
        else $error("held result while output register empty");

    a_no_accept_pending: assert property (@(posedge clk) disable iff (!rst_n)
        y_pend_reg |-> in_stall)
        else $error("word accepted while a result is held back");

    a_result_after_m1: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_M1) |=> (out_valid_reg || y_pend_reg))
        else $error("result lost after output step");
`endif

endmodule

// File: tb/sv/tb_top.sv
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import biq_pkg::*;

    // Coefficient extremes and the first register index past the bank
    localparam coeff_t COEFF_MAX = 16'sh7FFF;
    localparam coeff_t COEFF_MIN = 16'sh8000;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = REG_A2 + 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = '1;

    // Pause after the last output before touching the coefficients
    localparam int SETTLE_CYCLES  = 8;
    // Output hold-off long enough to back the pipeline up into the input
    localparam int LONG_HOLD      = 400;
    // Cycles with no word moving on any channel before the run is aborted
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_WORDS    = 104;
    localparam int PRINT_CAP      = 50;

    typedef struct {
        sample_t    sample;
        logic       clear;
    } audio_word_t;

    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 in_valid    = 1'b0;
    logic                 in_stall;
    sample_t              sample_in   = '0;
    logic                 clear_state = 1'b0;
    logic                 out_valid;
    logic                 out_stall   = 1'b0;
    sample_t              sample_out;
    logic                 cfg_valid   = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index   = '0;
    coeff_t               cfg_data    = '0;

    // Words waiting to be offered, and filter outputs predicted for accepted words
    audio_word_t sample_q [$];
    sample_t     filtered_q [$];

    // Shadow of the coefficient bank and of the two filter accumulators
    coeff_t coef_shadow [NUM_COEFFS] = '{B0_RESET, '0, '0, '0, '0};
    acc_t   tap1_acc = '0;
    acc_t   tap2_acc = '0;

    int          gap_left    = 0;
    int          stall_left  = 0;
    int          idle_cycles = 0;
    int unsigned n_in        = 0;
    int unsigned n_out       = 0;
    int unsigned n_cfg       = 0;
    int unsigned n_err       = 0;
    int unsigned n_settings  = 1;
    int unsigned n_clears    = 0;

    // Control flags, changed only on the falling edge
    bit no_idle    = 1'b0;
    bit hold_start = 1'b0;

    biquad_iir_q14_saturating uut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .sample_in   (sample_in),
        .clear_state (clear_state),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .sample_out  (sample_out),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    task automatic report_error(input string msg);
        n_err++;
        if (n_err <= PRINT_CAP)
            $display("ERROR at %0t ns: %s", $time, msg);
    endtask

    // One filter step: clear, multiply-accumulate, round half up, clamp,
    // then advance both accumulators from the input and the clamped output.
    function automatic sample_t biquad_predict(input sample_t x, input logic clr);
        longint xl;
        longint yl;
        if (clr)
        begin
            tap1_acc = '0;
            tap2_acc = '0;
        end
        xl = x;
        yl = (xl * longint'(coef_shadow[REG_B0]) + longint'(tap1_acc)
              + longint'(ROUND_HALF)) >>> FRAC_BITS;
        if (yl > longint'(SAT_MAX))
            yl = SAT_MAX;
        else if (yl < longint'(SAT_MIN))
            yl = SAT_MIN;
        tap1_acc = acc_t'(longint'(tap2_acc) + xl * longint'(coef_shadow[REG_B1])
                          + yl * longint'(coef_shadow[REG_A1]));
        tap2_acc = acc_t'(xl * longint'(coef_shadow[REG_B2])
                          + yl * longint'(coef_shadow[REG_A2]));
        return sample_t'(yl);
    endfunction

    // Gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (no_idle)
            return 0;
        if (r < 12)
            return 0;
        if (r < 18)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic sample_t pick_sample();
        case ($urandom_range(0, 9))
            0:       return SAT_MAX;
            1:       return SAT_MIN;
            2:       return sample_t'(int'($urandom_range(0, 63)) - 32);
            3, 4:    return sample_t'(int'($urandom_range(0, 131071)) - 65536);
            default: return sample_t'($urandom);
        endcase
    endfunction

    function automatic coeff_t pick_coeff();
        case ($urandom_range(0, 7))
            0:       return COEFF_MAX;
            1:       return COEFF_MIN;
            2:       return '0;
            3:       return B0_RESET;
            default: return coeff_t'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Input driver: offer queued words, hold a stalled word unchanged, and
    // predict the filter output for every word the block takes.
    // Each output gets at most one nonblocking assignment per edge.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : in_drive
        audio_word_t nxt;
        int          g;
        if (!rst_n)
        begin
            in_valid    <= 1'b0;
            sample_in   <= '0;
            clear_state <= 1'b0;
            gap_left    <= 0;
        end
        else
        begin
            g = gap_left;
            if (in_valid && !in_stall)
            begin
                filtered_q.push_back(biquad_predict(sample_in, clear_state));
                n_in++;
                if (clear_state)
                    n_clears++;
                g = pick_gap();
            end
            if (in_valid && in_stall)
            begin
                // hold: the word stays on the bus until taken
            end
            else if (g > 0)
            begin
                in_valid <= 1'b0;
                g--;
            end
            else if (sample_q.size() != 0)
            begin
                nxt = sample_q.pop_front();
                sample_in   <= nxt.sample;
                clear_state <= nxt.clear;
                in_valid    <= 1'b1;
            end
            else
            begin
                in_valid <= 1'b0;
            end
            gap_left <= g;
        end
    end

    // ------------------------------------------------------------------
    // Output stall: random runs of back-pressure, none while no_idle is
    // set, and one long hold-off on request that fills the block up.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : out_pressure
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else if (hold_start)
        begin
            out_stall  <= 1'b1;
            stall_left <= LONG_HOLD;
        end
        else if (stall_left > 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (no_idle || $urandom_range(0, 3) != 0)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            out_stall  <= 1'b1;
            stall_left <= pick_gap();
        end
    end

    // ------------------------------------------------------------------
    // Output check: compare each taken word with the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : out_check
        sample_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            n_out++;
            if (filtered_q.size() == 0)
            begin
                report_error($sformatf("output word %0d (%0d) with no input pending",
                                       n_out, sample_out));
            end
            else
            begin
                want = filtered_q.pop_front();
                if (sample_out !== want)
                    report_error($sformatf("output word %0d: sample_out %0d, want %0d",
                                           n_out, sample_out, want));
            end
        end
    end

    // Abort when no word moves on any channel for too long
    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no progress for %0d cycles, %0d outputs still pending",
                     idle_cycles, filtered_q.size());
            $display("tb_top: done, errors");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Write one coefficient register; indexes past the bank must be ignored
    task automatic load_coeff(input logic [CFG_IDX_W-1:0] idx, input coeff_t val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx <= REG_A2)
            coef_shadow[idx] = val;
        n_cfg++;
        cfg_valid <= 1'b0;
    endtask

    task automatic load_bank(input coeff_t b0, input coeff_t b1, input coeff_t b2,
                             input coeff_t a1, input coeff_t a2);
        load_coeff(REG_B0, b0);
        load_coeff(REG_B1, b1);
        load_coeff(REG_B2, b2);
        load_coeff(REG_A1, a1);
        load_coeff(REG_A2, a2);
        n_settings++;
    endtask

    task automatic queue_sample(input sample_t s, input logic clr);
        audio_word_t w;
        w.sample = s;
        w.clear  = clr;
        sample_q.push_back(w);
    endtask

    // Stop the sender until every predicted output has been taken
    task automatic wait_drained();
        do
            @(negedge clk);
        while (sample_q.size() != 0 || in_valid || filtered_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    initial
    begin : stimulus
        // Reset once; release on a rising edge
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Reset coefficients: unity gain, no feedback; output equals input
        @(negedge clk);
        queue_sample(SAT_MAX, 1'b1);
        queue_sample(SAT_MIN, 1'b0);
        queue_sample('0, 1'b0);
        queue_sample(-32'sd1, 1'b0);
        queue_sample(32'sd1, 1'b0);
        queue_sample(32'sh1234_5678, 1'b1);
        queue_sample(-32'sd5, 1'b0);
        wait_drained();

        // Extreme coefficients: both saturation rails, clamped value fed back
        load_bank(COEFF_MIN, COEFF_MAX, COEFF_MIN, COEFF_MAX, COEFF_MIN);
        @(negedge clk);
        queue_sample(SAT_MAX, 1'b1);
        queue_sample(SAT_MIN, 1'b0);
        queue_sample(SAT_MAX, 1'b0);
        queue_sample('0, 1'b0);
        queue_sample('0, 1'b0);
        queue_sample(SAT_MIN, 1'b1);
        queue_sample(32'sd1, 1'b0);
        wait_drained();

        // Tiny gain exposes rounding of exact halves toward plus infinity;
        // writes past the bank must leave it alone
        load_bank(16'sd1, '0, '0, '0, '0);
        load_coeff(REG_SPARE_FIRST, COEFF_MAX);
        load_coeff(REG_SPARE_LAST, COEFF_MIN);
        load_coeff(REG_SPARE_FIRST + 3'd1, coeff_t'($urandom));
        @(negedge clk);
        queue_sample(32'sd8192, 1'b1);
        queue_sample(-32'sd8192, 1'b0);
        queue_sample(32'sd24576, 1'b0);
        queue_sample(-32'sd24576, 1'b0);
        queue_sample(32'sd8191, 1'b0);
        queue_sample(-32'sd8193, 1'b0);
        queue_sample(32'sd40960, 1'b1);
        wait_drained();

        // Random phases, each with a fresh coefficient bank
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            if (p % 2 == 1)
            begin
                // Stable poles: output tracks the input instead of pinning a rail
                load_bank(coeff_t'(int'($urandom_range(0, 16384)) - 8192),
                          coeff_t'(int'($urandom_range(0, 16384)) - 8192),
                          coeff_t'(int'($urandom_range(0, 16384)) - 8192),
                          coeff_t'(int'($urandom_range(0, 16384)) - 8192),
                          coeff_t'(int'($urandom_range(0, 8192)) - 4096));
            end
            else
            begin
                load_bank(pick_coeff(), pick_coeff(), pick_coeff(), pick_coeff(),
                          pick_coeff());
            end
            if ($urandom_range(0, 2) == 0)
                load_coeff(REG_SPARE_FIRST + 3'($urandom_range(0, 2)), coeff_t'($urandom));

            @(negedge clk);
            no_idle = (p == 0);
            for (int i = 0; i < PHASE_WORDS; i++)
            begin
                queue_sample(pick_sample(), $urandom_range(0, 19) == 0);
                // Pause the sender mid-phase until everything has come out
                if (p == 5 && i == PHASE_WORDS / 2)
                    wait_drained();
            end

            if (p == 3)
            begin
                // Hold the output off for a long stretch while words keep coming
                @(negedge clk);
                hold_start = 1'b1;
                @(negedge clk);
                hold_start = 1'b0;
            end
            wait_drained();
            no_idle = 1'b0;
        end

        if (filtered_q.size() != 0)
            report_error($sformatf("%0d predicted outputs never arrived", filtered_q.size()));

        $display("covered %0d input words (%0d with state clear) and %0d outputs checked",
                 n_in, n_clears, n_out);
        $display("over %0d coefficient settings via %0d register writes, incl. spare indexes",
                 n_settings, n_cfg);
        if (n_err == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

// File: sim.f
rtl/biq_pkg.sv
rtl/biq_mul.sv
rtl/biq_cfg.sv
rtl/biquad_iir_q14_saturating.sv
tb/sv/tb_top.sv
